// File: design/tcw_pkg.sv
// Package for the text console writer: screen geometry, codes and the command type.
`default_nettype none
package tcw_pkg;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam int CELL_W = 11;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CELL_W-1:0] LAST_CELL      = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'(CELLS - COLS);
  localparam logic [CELL_W-1:0] END_CELL       = CELL_W'(CELLS);
  localparam logic [CELL_W-1:0] COLS_CELL      = CELL_W'(COLS);
  localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLS - 1);

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BLANK   = 8'h08;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_BACK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BLANK,
    OP_BACK,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e           op;
    logic [7:0]        ch;
    logic [CELL_W-1:0] addr;
  } tcw_cmd_t;

endpackage
`default_nettype wire

// File: design/tcw_cmd_if.sv
// Command channel interface of the text console writer.
`default_nettype none
interface tcw_cmd_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        char_code;
  logic [CELL_W-1:0] cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink (input valid, kind, char_code, cell_index, output ready);
endinterface
`default_nettype wire

// File: design/tcw_rsp_if.sv
// Result channel interface of the text console writer.
`default_nettype none
interface tcw_rsp_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cursor_cell;
  logic [7:0]        read_char;
  logic [7:0]        read_attribute;

  modport source (output valid, cursor_cell, read_char, read_attribute, input ready);
  modport sink (input valid, cursor_cell, read_char, read_attribute, output ready);
endinterface
`default_nettype wire

// File: design/tcw_front.sv
// Front end: accepts command words and classifies them into internal operations.
`default_nettype none
module tcw_front
  import tcw_pkg::*;
(
  tcw_cmd_if.sink   cmd_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output tcw_cmd_t  push_cmd_o
);

  always_comb begin
    push_cmd_o.ch   = cmd_i.char_code;
    push_cmd_o.addr = cmd_i.cell_index;
    unique case (cmd_i.kind)
      KIND_PUT: begin
        if (cmd_i.char_code == CHAR_NEWLINE) begin
          push_cmd_o.op = OP_NEWLINE;
        end else if (cmd_i.char_code == CHAR_BLANK) begin
          push_cmd_o.op = OP_BLANK;
        end else begin
          push_cmd_o.op = OP_PUT;
        end
      end
      KIND_BACK:  push_cmd_o.op = OP_BACK;
      KIND_CLEAR: push_cmd_o.op = OP_CLEAR;
      KIND_READ: begin
        if (cmd_i.cell_index < END_CELL) begin
          push_cmd_o.op = OP_READ;
        end else begin
          push_cmd_o.op = OP_NOP;
        end
      end
      default: push_cmd_o.op = OP_NOP;
    endcase
  end

  assign push_valid_o = cmd_i.valid;
  assign cmd_i.ready  = push_ready_i;

endmodule
`default_nettype wire

// File: design/tcw_fifo.sv
// Short command queue between the front end and the execution unit.
`default_nettype none
module tcw_fifo
  import tcw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  tcw_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output tcw_cmd_t pop_cmd_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tcw_cmd_t         slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// File: design/tcw_exec.sv
// Execution unit: cursor, cell memory, scroll and clear sweeps, and the result register.
`default_nettype none
module tcw_exec
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        attr_we_i,
  input  logic [7:0]  attr_wdata_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  tcw_cmd_t    pop_cmd_i,
  tcw_rsp_if.source   rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_ZERO,
    S_CLEAR
  } state_e;

  state_e            state_q, state_d;
  logic [CELL_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0] ptr_q, ptr_d;
  logic              copy_v_q, copy_v_d;
  logic [CELL_W-1:0] copy_addr_q, copy_addr_d;
  logic [7:0]        attr_q;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] out_cursor_q, out_cursor_d;
  logic [7:0]        out_char_q, out_char_d;
  logic [7:0]        out_attr_q, out_attr_d;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_q;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [CELL_W-1:0] mem_raddr;

  logic              out_free;
  logic [CELL_W-1:0] cur_dec;
  logic [COL_W-1:0]  col_inc, col_dec;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign cur_dec  = (cursor_q == '0) ? '0 : cursor_q - 1'b1;
  assign col_inc  = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
  assign col_dec  = (col_q == '0) ? LAST_COL : col_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    col_d        = col_q;
    ptr_d        = ptr_q;
    copy_v_d     = 1'b0;
    copy_addr_d  = copy_addr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_cursor_d = out_cursor_q;
    out_char_d   = out_char_q;
    out_attr_d   = out_attr_q;
    pop_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cursor_q;
    mem_wdata    = {attr_q, CHAR_SPACE};
    mem_raddr    = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        pop_ready_o = out_free;
        if (pop_valid_i && out_free) begin
          out_char_d = '0;
          out_attr_d = '0;
          unique case (pop_cmd_i.op)
            OP_PUT: begin
              mem_we    = 1'b1;
              mem_wdata = {attr_q, pop_cmd_i.ch};
              if (cursor_q == LAST_CELL) begin
                cursor_d = LAST_ROW_START;
                col_d    = '0;
                ptr_d    = COLS_CELL;
                state_d  = S_SCROLL;
              end else begin
                cursor_d     = cursor_q + 1'b1;
                col_d        = col_inc;
                out_valid_d  = 1'b1;
                out_cursor_d = cursor_q + 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (cursor_q >= LAST_ROW_START) begin
                cursor_d = LAST_ROW_START;
                ptr_d    = COLS_CELL;
                state_d  = S_SCROLL;
              end else begin
                cursor_d     = cursor_q - CELL_W'(col_q) + COLS_CELL;
                out_valid_d  = 1'b1;
                out_cursor_d = cursor_q - CELL_W'(col_q) + COLS_CELL;
              end
            end
            OP_BLANK: begin
              mem_we       = 1'b1;
              out_valid_d  = 1'b1;
              out_cursor_d = cursor_q;
            end
            OP_BACK: begin
              mem_we       = 1'b1;
              mem_waddr    = cur_dec;
              cursor_d     = cur_dec;
              if (cursor_q != '0) begin
                col_d = col_dec;
              end
              out_valid_d  = 1'b1;
              out_cursor_d = cur_dec;
            end
            OP_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
              ptr_d    = '0;
              state_d  = S_CLEAR;
            end
            OP_READ: begin
              mem_raddr = pop_cmd_i.addr;
              state_d   = S_READ;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_cursor_d = cursor_q;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d  = 1'b1;
        out_cursor_d = cursor_q;
        out_char_d   = rdata_q[7:0];
        out_attr_d   = rdata_q[15:8];
        state_d      = S_IDLE;
      end
      S_SCROLL: begin
        mem_we    = copy_v_q;
        mem_waddr = copy_addr_q;
        mem_wdata = rdata_q;
        if (ptr_q != END_CELL) begin
          copy_v_d    = 1'b1;
          copy_addr_d = ptr_q - COLS_CELL;
          ptr_d       = ptr_q + 1'b1;
        end else begin
          ptr_d   = LAST_ROW_START;
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '0;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          out_valid_d  = 1'b1;
          out_cursor_d = cursor_q;
          state_d      = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          out_valid_d  = 1'b1;
          out_cursor_d = cursor_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_q     <= '0;
      col_q        <= '0;
      ptr_q        <= '0;
      copy_v_q     <= 1'b0;
      copy_addr_q  <= '0;
      attr_q       <= ATTR_RESET;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_char_q   <= '0;
      out_attr_q   <= '0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      col_q        <= col_d;
      ptr_q        <= ptr_d;
      copy_v_q     <= copy_v_d;
      copy_addr_q  <= copy_addr_d;
      out_valid_q  <= out_valid_d;
      out_cursor_q <= out_cursor_d;
      out_char_q   <= out_char_d;
      out_attr_q   <= out_attr_d;
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr[ADDR_W-1:0]];
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cursor_cell    = out_cursor_q;
  assign rsp_o.read_char      = out_char_q;
  assign rsp_o.read_attribute = out_attr_q;

endmodule
`default_nettype wire

// File: design/text_console_writer.sv
// Top level of the text console writer: front end, command queue and execution unit.
//
// Commands arrive as words on the cmd_i channel (valid/ready) and each one yields
// exactly one result word on the rsp_o channel, carrying the cursor cell after the
// command and, for a cell read, that cell's character and attribute bytes.
// The attribute register is written through attr_we_i and attr_wdata_i; the user is
// to write it only while the block is idle, which the block itself does not enforce.
// It resets to 0x0F. A put, newline, blank or backspace that does not scroll is
// handled in S_IDLE of the execution unit; with the unit free its result word is
// valid in the cycle after the unit accepts it, and while the receiver takes them
// such words can follow one a cycle. An in-range read passes through S_READ, as the
// cell memory read port is registered: the cell goes to rdata_q, then to the result
// register. A scroll copies the store one cell a cycle through that single read and
// write port and then zeroes the last row. A clear writes one cell a cycle.
// The queue between the front end and the execution unit holds QUEUE_DEPTH_P words
// (QUEUE_DEPTH by default), so commands are still accepted while a long sweep runs
// or a result waits. When the receiver stalls, the result register holds its word
// and the unit stops; the queue then fills and cmd_i.ready falls.
// Reset clears the cursor, the queue and the result register; the cell store is not
// cleared, and cells are to be read only after a clear command.
`default_nettype none
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       attr_we_i,
  input  logic [7:0] attr_wdata_i,
  tcw_cmd_if.sink    cmd_i,
  tcw_rsp_if.source  rsp_o
);

  logic     push_valid, push_ready;
  tcw_cmd_t push_cmd;
  logic     pop_valid, pop_ready;
  tcw_cmd_t pop_cmd;

  tcw_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  tcw_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tcw_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_we_i    (attr_we_i),
    .attr_wdata_i (attr_wdata_i),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .rsp_o        (rsp_o)
  );

endmodule
`default_nettype wire

// File: tb/tcw_result_checker.sv
// Checker for the text console writer: watches both channels, predicts each result word and compares it.
module tcw_result_checker
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       attr_we_i,
  input  logic [7:0] attr_wdata_i,
  tcw_cmd_if         cmd_mon,
  tcw_rsp_if         rsp_mon,
  output int         error_count,
  output int         results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CELL_W-1:0] cursor_cell;
    logic [7:0]        read_char;
    logic [7:0]        read_attribute;
  } console_result_t;

  logic [15:0]     screen_cells [CELLS];
  int              cursor_pos;
  logic [7:0]      text_attr;
  console_result_t expected_q [$];

  initial begin
    error_count     = 0;
    results_waiting = 0;
    cursor_pos      = 0;
    text_attr       = ATTR_RESET;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic scroll_if_past_end();
    if (cursor_pos >= CELLS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_cells[i] = screen_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[i] = '0;
      cursor_pos -= COLS;
    end
  endtask

  task automatic write_char(input logic [7:0] code);
    if (cursor_pos >= CELLS) cursor_pos = 0;
    if (code == CHAR_NEWLINE) begin
      cursor_pos = (cursor_pos / COLS + 1) * COLS;
    end else if (code == CHAR_BLANK) begin
      screen_cells[cursor_pos] = {text_attr, CHAR_SPACE};
    end else begin
      screen_cells[cursor_pos] = {text_attr, code};
      cursor_pos++;
    end
    scroll_if_past_end();
  endtask

  task automatic predict_command(input logic [1:0] kind, input logic [7:0] code,
                                 input logic [CELL_W-1:0] idx);
    console_result_t res;
    res = '0;
    case (kind)
      KIND_PUT: begin
        write_char(code);
      end
      KIND_BACK: begin
        if (cursor_pos > 0) cursor_pos--;
        write_char(CHAR_BLANK);
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_cells[i] = {text_attr, CHAR_SPACE};
        cursor_pos = 0;
      end
      default: begin
        if (idx < CELLS) begin
          res.read_char      = screen_cells[idx][7:0];
          res.read_attribute = screen_cells[idx][15:8];
        end
      end
    endcase
    res.cursor_cell = CELL_W'(cursor_pos);
    expected_q.push_back(res);
  endtask

  task automatic check_result(input logic [CELL_W-1:0] cur, input logic [7:0] ch,
                              input logic [7:0] attr);
    console_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected, cursor_cell %0d", cur));
    end else begin
      want = expected_q.pop_front();
      if (cur !== want.cursor_cell)
        report_mismatch($sformatf("cursor_cell expected %0d, got %0d", want.cursor_cell, cur));
      if (ch !== want.read_char)
        report_mismatch($sformatf("read_char expected %02h, got %02h", want.read_char, ch));
      if (attr !== want.read_attribute)
        report_mismatch($sformatf("read_attribute expected %02h, got %02h",
                                  want.read_attribute, attr));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_pos = 0;
      text_attr  = ATTR_RESET;
      expected_q.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        predict_command(cmd_mon.kind, cmd_mon.char_code, cmd_mon.cell_index);
      if (rsp_mon.valid && rsp_mon.ready)
        check_result(rsp_mon.cursor_cell, rsp_mon.read_char, rsp_mon.read_attribute);
      if (attr_we_i) text_attr = attr_wdata_i;
    end
    results_waiting = expected_q.size();
  end

endmodule

// File: tb/tb_text_console_writer.sv
// Top of the text console writer testbench: clock, reset, command and result drivers, verdict.
module tb_text_console_writer;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_WORDS = 400;
  localparam int HOLD_CYCLES = 120;

  logic       clk;
  logic       rst_n;
  logic       attr_we;
  logic [7:0] attr_wdata;
  int         error_count;
  int         results_waiting;
  bit         quiet_tail;
  bit         long_hold_req;
  bit         screen_cleared;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .attr_we_i    (attr_we),
    .attr_wdata_i (attr_wdata),
    .cmd_i        (cmd_ch),
    .rsp_o        (rsp_ch)
  );

  tcw_result_checker checker_u (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .attr_we_i       (attr_we),
    .attr_wdata_i    (attr_wdata),
    .cmd_mon         (cmd_ch),
    .rsp_mon         (rsp_ch),
    .error_count     (error_count),
    .results_waiting (results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic [1:0] kind, input logic [7:0] code,
                           input logic [CELL_W-1:0] idx);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= kind;
    cmd_ch.char_code  <= code;
    cmd_ch.cell_index <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    if (kind == KIND_CLEAR) screen_cleared = 1'b1;
  endtask

  function automatic logic [CELL_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (!screen_cleared || r >= 90) return CELL_W'($urandom_range(CELLS, 2**CELL_W - 1));
    if (r >= 80) return CELL_W'($urandom_range(CELLS - COLS, CELLS - 1));
    return CELL_W'($urandom_range(0, CELLS - 1));
  endfunction

  task automatic random_step(inout int sent);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(20, 80);
      repeat (n) send_word(KIND_PUT, 8'($urandom_range(8'h20, 8'h7E)), CELL_W'($urandom));
      send_word(KIND_PUT, CHAR_NEWLINE, CELL_W'($urandom));
      sent += n + 1;
    end else if (r < 11) begin
      n = $urandom_range(3, 8);
      repeat (n) send_word(KIND_PUT, CHAR_NEWLINE, CELL_W'($urandom));
      sent += n;
    end else if (r < 14) begin
      repeat (5) send_word(KIND_READ, 8'($urandom), pick_cell());
      sent += 5;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60)      send_word(KIND_PUT, 8'($urandom), CELL_W'($urandom));
      else if (r < 65) send_word(KIND_PUT, CHAR_NEWLINE, CELL_W'($urandom));
      else if (r < 69) send_word(KIND_PUT, CHAR_BLANK, CELL_W'($urandom));
      else if (r < 77) send_word(KIND_BACK, 8'($urandom), CELL_W'($urandom));
      else if (r < 78) send_word(KIND_CLEAR, 8'($urandom), CELL_W'($urandom));
      else             send_word(KIND_READ, 8'($urandom), pick_cell());
      sent += 1;
    end
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    attr_we    <= 1'b1;
    attr_wdata <= value;
    @(negedge clk);
    attr_we    <= 1'b0;
    @(negedge clk);
  endtask

  // The receiver stalls in short random bursts, and once for a long stretch so that the
  // command queue fills and the block holds off further words.
  initial begin
    int hold_count;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        rsp_ch.ready <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        long_hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [7:0] phase_attr [4];
    int         sent;
    bit         hold_sent;
    rst_n             = 1'b0;
    attr_we           = 1'b0;
    attr_wdata        = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = KIND_PUT;
    cmd_ch.char_code  = '0;
    cmd_ch.cell_index = '0;
    quiet_tail        = 1'b0;
    long_hold_req     = 1'b0;
    screen_cleared    = 1'b0;
    hold_sent         = 1'b0;
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = 8'($urandom_range(1, 254));
    phase_attr[3] = 8'($urandom_range(1, 254));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // No cell may be read before the first clear, so only an out-of-range read comes first.
    send_word(KIND_READ, 8'h00, CELL_W'(2**CELL_W - 1));
    send_word(KIND_PUT, 8'hFF, '0);
    send_word(KIND_CLEAR, 8'h00, '0);
    send_word(KIND_READ, 8'h00, '0);
    send_word(KIND_BACK, 8'h00, '0);
    send_word(KIND_PUT, 8'h00, '0);
    send_word(KIND_PUT, 8'hFF, '0);
    send_word(KIND_PUT, 8'h41, '0);
    send_word(KIND_PUT, CHAR_BLANK, '0);
    send_word(KIND_BACK, 8'hFF, CELL_W'(2**CELL_W - 1));
    send_word(KIND_PUT, CHAR_NEWLINE, '0);
    send_word(KIND_PUT, 8'h78, '0);
    send_word(KIND_READ, 8'h00, CELL_W'(1));
    send_word(KIND_READ, 8'h00, COLS_CELL);
    send_word(KIND_READ, 8'h00, LAST_CELL);
    send_word(KIND_READ, 8'h00, END_CELL);
    send_word(KIND_READ, 8'h00, CELL_W'(1024));

    // The first phase opens with enough newlines to reach the last row and scroll.
    repeat (26) send_word(KIND_PUT, CHAR_NEWLINE, CELL_W'($urandom));
    repeat (4) send_word(KIND_READ, 8'h00, CELL_W'($urandom_range(CELLS - COLS, CELLS - 1)));

    sent = 0;
    while (sent < PHASE_WORDS) begin
      if (!hold_sent && sent >= 100) begin
        long_hold_req = 1'b1;
        hold_sent     = 1'b1;
      end
      random_step(sent);
    end

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_attribute(phase_attr[p]);
      if (p == 3) quiet_tail = 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) random_step(sent);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0 && results_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: text_console_writer.f
design/tcw_pkg.sv
design/tcw_cmd_if.sv
design/tcw_rsp_if.sv
design/tcw_front.sv
design/tcw_fifo.sv
design/tcw_exec.sv
design/text_console_writer.sv
tb/tcw_result_checker.sv
tb/tb_text_console_writer.sv
